// ===== rtl/bbs_pkg.sv =====
// Package for the block bounding sphere: field widths, default block size
// and the sequencer state type. No dependencies.
package bbs_pkg;

  localparam int unsigned CoordW          = 24;
  localparam int unsigned RadiusW         = 25;
  localparam int unsigned DistW           = 52;
  localparam int unsigned RootW           = DistW / 2;
  localparam int unsigned MaxBlockPtsDef  = 256;

  typedef logic signed [CoordW-1:0] coord_t;

  typedef enum logic [2:0] {
    S_LOAD,
    S_DIV_LD,
    S_DIV_RUN,
    S_RD,
    S_DIST,
    S_SQ_LD,
    S_SQ_RUN,
    S_OUT
  } bbs_state_e;

endpackage

// ===== rtl/block_bounding_sphere.sv =====
// Block bounding sphere: point store, axis sums, shared serial divider,
// shared squarer and serial square root under one sequencer. Uses bbs_pkg.
//
// Usage: points enter on the input channel (in_valid_i / in_stall_o), one
// per cycle while the block is loading. last_point_i closes the block; the
// block then stalls its input until the result transaction (centroid and
// radius) has been taken on the output channel (out_valid_o / out_stall_i).
// Points beyond MAX_BLOCK_POINTS are dropped, but a dropped last point still
// closes the block.
// Closing sequence after the last point: the three centroid divisions (one
//   quotient bit a cycle in the shared divider), the distance pass (each point
//   read from the store and its three axis squares formed in the shared
//   squarer), and the square root (one root bit a cycle), then the result.
// Throughput: one point per cycle while loading; the block is busy for the
// whole closing sequence. The result holds while out_stall_i is high.
// Reset clears the sums, the point count and the sequencer; the point store
// needs no clearing since only entries of the current block are read.
module block_bounding_sphere #(
  parameter int unsigned MAX_BLOCK_POINTS = bbs_pkg::MaxBlockPtsDef
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic signed [bbs_pkg::CoordW-1:0]  point_x_i,
  input  logic signed [bbs_pkg::CoordW-1:0]  point_y_i,
  input  logic signed [bbs_pkg::CoordW-1:0]  point_z_i,
  input  logic                               last_point_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic signed [bbs_pkg::CoordW-1:0]  center_x_o,
  output logic signed [bbs_pkg::CoordW-1:0]  center_y_o,
  output logic signed [bbs_pkg::CoordW-1:0]  center_z_o,
  output logic        [bbs_pkg::RadiusW-1:0] radius_o
);
  import bbs_pkg::*;

  localparam int unsigned CntW = $clog2(MAX_BLOCK_POINTS + 1);
  localparam int unsigned AddrW = (MAX_BLOCK_POINTS > 1) ? $clog2(MAX_BLOCK_POINTS) : 1;
  localparam int unsigned SumW = CoordW + CntW;
  localparam int unsigned DivCntW = $clog2(SumW + 1);
  localparam int unsigned SqCntW = $clog2(RootW + 1);
  localparam int unsigned MagW = CoordW + 1;
  localparam int unsigned SqW = 2 * MagW;

  bbs_state_e state_q, state_d;

  logic [3*CoordW-1:0] mem [MAX_BLOCK_POINTS];
  logic [3*CoordW-1:0] rd_data_q;

  logic signed [SumW-1:0] sum_q [3];
  logic [CntW-1:0]        count_q;
  coord_t                 center_q [3];
  logic [1:0]             axis_q;

  logic [SumW-1:0]    dq_q;
  logic [CntW-1:0]    rem_q;
  logic [DivCntW-1:0] div_cnt_q;
  logic               neg_q;

  logic [CntW-1:0]    idx_q;
  logic [2:0]         step_q;
  logic [SqW-1:0]     sq_q;
  logic [DistW-1:0]   acc_q;
  logic [DistW-1:0]   max_q;

  logic [DistW-1:0]   sn_q;
  logic [RootW:0]     srem_q;
  logic [RootW-1:0]   root_q;
  logic [SqCntW-1:0]  sq_cnt_q;
  logic [RadiusW-1:0] radius_q;

  logic in_acc, out_acc, keep;
  logic div_done, sq_done, last_idx;

  logic [CntW:0]          rem_sh;
  logic [CntW:0]          rem_sub;
  logic [SumW-1:0]        sum_mag;
  coord_t                 st_coord;
  logic signed [MagW-1:0] diff;
  logic [MagW-1:0]        mag;
  logic [RootW+2:0]       srem_t;
  logic [RootW+2:0]       strial;
  logic [RootW+2:0]       ssub;

  assign in_acc   = in_valid_i && !in_stall_o;
  assign out_acc  = out_valid_o && !out_stall_i;
  assign keep     = count_q < CntW'(MAX_BLOCK_POINTS);
  assign div_done = div_cnt_q == DivCntW'(SumW - 1);
  assign sq_done  = sq_cnt_q == SqCntW'(RootW - 1);
  assign last_idx = idx_q == count_q - CntW'(1);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_LOAD:    if (in_acc && last_point_i) state_d = S_DIV_LD;
      S_DIV_LD:  state_d = S_DIV_RUN;
      S_DIV_RUN: begin
        if (div_done) state_d = (axis_q == 2'd2) ? S_RD : S_DIV_LD;
      end
      S_RD:      state_d = S_DIST;
      S_DIST: begin
        if (step_q == 3'd4) state_d = last_idx ? S_SQ_LD : S_RD;
      end
      S_SQ_LD:   state_d = S_SQ_RUN;
      S_SQ_RUN:  if (sq_done) state_d = S_OUT;
      S_OUT:     if (out_acc) state_d = S_LOAD;
      default:   state_d = S_LOAD;
    endcase
  end

  always_comb begin
    in_stall_o  = 1'b1;
    out_valid_o = 1'b0;
    unique case (state_q)
      S_LOAD:  in_stall_o = 1'b0;
      S_OUT:   out_valid_o = 1'b1;
      default: ;
    endcase
  end

  always_comb begin
    rem_sh   = {rem_q, dq_q[SumW-1]};
    rem_sub  = rem_sh - {1'b0, count_q};
    sum_mag  = sum_q[axis_q][SumW-1] ? SumW'(-sum_q[axis_q]) : SumW'(sum_q[axis_q]);
    case (step_q[1:0])
      2'd0:    st_coord = rd_data_q[CoordW-1:0];
      2'd1:    st_coord = rd_data_q[2*CoordW-1:CoordW];
      default: st_coord = rd_data_q[3*CoordW-1:2*CoordW];
    endcase
    diff   = {st_coord[CoordW-1], st_coord}
           - {center_q[step_q[1:0]][CoordW-1], center_q[step_q[1:0]]};
    mag    = diff[MagW-1] ? MagW'(-diff) : MagW'(diff);
    srem_t = {srem_q, sn_q[DistW-1:DistW-2]};
    strial = {1'b0, root_q, 2'b01};
    ssub   = srem_t - strial;
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && keep) begin
      mem[count_q[AddrW-1:0]] <= {point_z_i, point_y_i, point_x_i};
    end
    rd_data_q <= mem[idx_q[AddrW-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_LOAD;
      count_q   <= '0;
      sum_q[0]  <= '0;
      sum_q[1]  <= '0;
      sum_q[2]  <= '0;
      axis_q    <= '0;
      div_cnt_q <= '0;
      idx_q     <= '0;
      step_q    <= '0;
      max_q     <= '0;
      sq_cnt_q  <= '0;
    end else begin
      state_q <= state_d;
      unique case (state_q)
        S_LOAD: begin
          axis_q <= '0;
          if (in_acc && keep) begin
            count_q  <= count_q + CntW'(1);
            sum_q[0] <= sum_q[0] + SumW'(point_x_i);
            sum_q[1] <= sum_q[1] + SumW'(point_y_i);
            sum_q[2] <= sum_q[2] + SumW'(point_z_i);
          end
        end
        S_DIV_LD: div_cnt_q <= '0;
        S_DIV_RUN: begin
          div_cnt_q <= div_cnt_q + DivCntW'(1);
          if (div_done) axis_q <= axis_q + 2'd1;
          idx_q  <= '0;
          step_q <= '0;
          max_q  <= '0;
        end
        S_RD: step_q <= '0;
        S_DIST: begin
          step_q <= step_q + 3'd1;
          if (step_q == 3'd4) begin
            if (acc_q > max_q) max_q <= acc_q;
            idx_q <= idx_q + CntW'(1);
          end
        end
        S_SQ_LD:  sq_cnt_q <= '0;
        S_SQ_RUN: sq_cnt_q <= sq_cnt_q + SqCntW'(1);
        S_OUT: begin
          if (out_acc) begin
            count_q  <= '0;
            sum_q[0] <= '0;
            sum_q[1] <= '0;
            sum_q[2] <= '0;
            max_q    <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      S_DIV_LD: begin
        dq_q  <= sum_mag;
        rem_q <= '0;
        neg_q <= sum_q[axis_q][SumW-1];
      end
      S_DIV_RUN: begin
        if (!rem_sub[CntW]) begin
          rem_q <= rem_sub[CntW-1:0];
          dq_q  <= {dq_q[SumW-2:0], 1'b1};
        end else begin
          rem_q <= rem_sh[CntW-1:0];
          dq_q  <= {dq_q[SumW-2:0], 1'b0};
        end
        if (div_done) begin
          if (!rem_sub[CntW]) begin
            center_q[axis_q] <= neg_q ? coord_t'(~{dq_q[SumW-2:0], 1'b1} + SumW'(1))
                                      : coord_t'({dq_q[SumW-2:0], 1'b1});
          end else begin
            center_q[axis_q] <= neg_q ? coord_t'(~{dq_q[SumW-2:0], 1'b0} + SumW'(1))
                                      : coord_t'({dq_q[SumW-2:0], 1'b0});
          end
        end
      end
      S_DIST: begin
        if (step_q < 3'd3) sq_q <= mag * mag;
        if (step_q == 3'd1) acc_q <= DistW'(sq_q);
        else if (step_q == 3'd2 || step_q == 3'd3) acc_q <= acc_q + DistW'(sq_q);
      end
      S_SQ_LD: begin
        sn_q   <= max_q;
        srem_q <= '0;
        root_q <= '0;
      end
      S_SQ_RUN: begin
        sn_q <= {sn_q[DistW-3:0], 2'b00};
        if (!ssub[RootW+2]) begin
          srem_q <= ssub[RootW:0];
          root_q <= {root_q[RootW-2:0], 1'b1};
          if (sq_done) radius_q <= RadiusW'({root_q[RootW-2:0], 1'b1});
        end else begin
          srem_q <= srem_t[RootW:0];
          root_q <= {root_q[RootW-2:0], 1'b0};
          if (sq_done) radius_q <= RadiusW'({root_q[RootW-2:0], 1'b0});
        end
      end
      default: ;
    endcase
  end

  assign center_x_o = center_q[0];
  assign center_y_o = center_q[1];
  assign center_z_o = center_q[2];
  assign radius_o   = radius_q;

endmodule

// ===== rtl/bbs_checker.sv =====
// Port-level checks for the block bounding sphere, bound to the top level.
// Depends on bbs_pkg for field widths.
module bbs_checker (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               in_valid_i,
  input logic                               in_stall_o,
  input logic                               last_point_i,
  input logic                               out_valid_o,
  input logic                               out_stall_i,
  input logic        [bbs_pkg::RadiusW-1:0] radius_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(radius_o))
    else $error("result transaction dropped or changed while stalled");

  a_busy_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("input taken while a result is pending");

  a_close_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && last_point_i |=> in_stall_o && !out_valid_o)
    else $error("block closed without a busy period");

  a_no_early: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && !last_point_i |=> !out_valid_o)
    else $error("result after a point that did not close the block");

endmodule

bind block_bounding_sphere bbs_checker u_bbs_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_stall_o   (in_stall_o),
  .last_point_i (last_point_i),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .radius_o     (radius_o)
);
